### rtl/lpi_pkg.sv
package lpi_pkg;

	localparam int FRAC_BITS   = 16;
	localparam int COORD_WIDTH = 32;
	localparam int WIDE        = 64;
	localparam int NUM_FIELDS  = 8;
	// divider: input stage, one stage per quotient bit, output stage
	localparam int DIV_LAT     = WIDE + 2;
	// multiplier: magnitudes, partial products, sum, sign, shift and saturate
	localparam int MUL_LAT     = 5;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic signed [WIDE-1:0]        wide_t;

	typedef struct packed {
		wide_t v;
		logic  clip;
	} sat_t;

	localparam wide_t WIDE_MAX = {1'b0, {(WIDE-1){1'b1}}};
	localparam wide_t WIDE_MIN = {1'b1, {(WIDE-1){1'b0}}};

	// magnitude of a signed wide value, most negative value maps to 2^(WIDE-1)
	function automatic logic [WIDE-1:0] mag(input wide_t a);
		logic [WIDE-1:0] r;
		r = a[WIDE-1] ? WIDE'(-a) : WIDE'(a);
		return r;
	endfunction

	function automatic sat_t sat_add(input wide_t a, input wide_t b);
		sat_t  r;
		wide_t s;
		s = a + b;
		r.v    = s;
		r.clip = 1'b0;
		if (a[WIDE-1] == b[WIDE-1] && s[WIDE-1] != a[WIDE-1]) begin
			r.clip = 1'b1;
			r.v    = a[WIDE-1] ? WIDE_MIN : WIDE_MAX;
		end
		return r;
	endfunction

	function automatic sat_t sat_sub(input wide_t a, input wide_t b);
		sat_t  r;
		wide_t s;
		s = a - b;
		r.v    = s;
		r.clip = 1'b0;
		if (a[WIDE-1] != b[WIDE-1] && s[WIDE-1] != a[WIDE-1]) begin
			r.clip = 1'b1;
			r.v    = a[WIDE-1] ? WIDE_MIN : WIDE_MAX;
		end
		return r;
	endfunction

	function automatic sat_t sat_shl(input wide_t a);
		sat_t                 r;
		logic [FRAC_BITS:0]   top;
		top    = a[WIDE-1:WIDE-1-FRAC_BITS];
		r.v    = a <<< FRAC_BITS;
		r.clip = 1'b0;
		if (!((&top) || !(|top))) begin
			r.clip = 1'b1;
			r.v    = a[WIDE-1] ? WIDE_MIN : WIDE_MAX;
		end
		return r;
	endfunction

endpackage

### rtl/lpi_div.sv
module lpi_div import lpi_pkg::*; (
	input  logic  clk,
	input  logic  en,
	input  wide_t num,
	input  wide_t den,
	output wide_t quo,
	output logic  ovf
);

	logic [WIDE-1:0] rem_s [WIDE+1];
	logic [WIDE-1:0] nq_s  [WIDE+1];
	logic [WIDE-1:0] d_s   [WIDE+1];
	logic            neg_s [WIDE+1];
	wide_t           quo_q;
	logic            ovf_q;

	// input stage: magnitudes and result sign
	// then one restoring step per stage, numerator bits shift out as quotient bits shift in
	always_ff @(posedge clk) begin
		logic [WIDE-1:0] trial;
		logic            fits;
		if (en) begin
			rem_s[0] <= '0;
			nq_s[0]  <= mag(num);
			d_s[0]   <= mag(den);
			neg_s[0] <= num[WIDE-1] ^ den[WIDE-1];
			for (int k = 0; k < WIDE; k++) begin
				trial = {rem_s[k][WIDE-2:0], nq_s[k][WIDE-1]};
				fits  = trial >= d_s[k];
				rem_s[k+1] <= fits ? trial - d_s[k] : trial;
				nq_s[k+1]  <= {nq_s[k][WIDE-2:0], fits};
				d_s[k+1]   <= d_s[k];
				neg_s[k+1] <= neg_s[k];
			end
		end
	end

	// output stage: apply sign, positive overflow saturates
	always_ff @(posedge clk) begin
		if (en) begin
			if (!neg_s[WIDE] && nq_s[WIDE][WIDE-1]) begin
				quo_q <= WIDE_MAX;
				ovf_q <= 1'b1;
			end else begin
				quo_q <= neg_s[WIDE] ? -wide_t'(nq_s[WIDE]) : wide_t'(nq_s[WIDE]);
				ovf_q <= 1'b0;
			end
		end
	end

	assign quo = quo_q;
	assign ovf = ovf_q;

endmodule

### rtl/lpi_mul.sv
module lpi_mul import lpi_pkg::*; (
	input  logic  clk,
	input  logic  en,
	input  wide_t a,
	input  wide_t b,
	output wide_t p,
	output logic  clip
);

	localparam int HALF = WIDE / 2;
	localparam int PW   = 2 * WIDE;

	logic [WIDE-1:0] ma_s1, mb_s1;
	logic            neg_s1, neg_s2, neg_s3;
	logic [WIDE-1:0] pp_s2 [4];
	logic [PW-1:0]   sum_s3;
	logic [PW-1:0]   prod_s4;
	wide_t           p_s5;
	logic            clip_s5;
	logic [PW-WIDE-FRAC_BITS:0] top;

	assign top = prod_s4[PW-1:WIDE+FRAC_BITS-1];

	always_ff @(posedge clk) begin
		if (en) begin
			// magnitudes and product sign
			ma_s1  <= mag(a);
			mb_s1  <= mag(b);
			neg_s1 <= a[WIDE-1] ^ b[WIDE-1];
			// four half-width partial products
			pp_s2[0] <= ma_s1[HALF-1:0] * mb_s1[HALF-1:0];
			pp_s2[1] <= ma_s1[HALF-1:0] * mb_s1[WIDE-1:HALF];
			pp_s2[2] <= ma_s1[WIDE-1:HALF] * mb_s1[HALF-1:0];
			pp_s2[3] <= ma_s1[WIDE-1:HALF] * mb_s1[WIDE-1:HALF];
			neg_s2   <= neg_s1;
			// full product magnitude
			sum_s3 <= {{WIDE{1'b0}}, pp_s2[0]}
				+ {{HALF{1'b0}}, pp_s2[1], {HALF{1'b0}}}
				+ {{HALF{1'b0}}, pp_s2[2], {HALF{1'b0}}}
				+ {pp_s2[3], {WIDE{1'b0}}};
			neg_s3 <= neg_s2;
			// signed product, shifting it later floors
			prod_s4 <= neg_s3 ? -sum_s3 : sum_s3;
			// shift out fraction and saturate to wide range
			if ((&top) || !(|top)) begin
				p_s5    <= prod_s4[WIDE+FRAC_BITS-1:FRAC_BITS];
				clip_s5 <= 1'b0;
			end else begin
				p_s5    <= prod_s4[PW-1] ? WIDE_MIN : WIDE_MAX;
				clip_s5 <= 1'b1;
			end
		end
	end

	assign p    = p_s5;
	assign clip = clip_s5;

endmodule

### rtl/line_pair_intersection.sv
// throughput: one line pair per cycle, set by the 66-stage dividers
// and the 5-stage multipliers, all fully pipelined
// a stall at the output holds every stage in place
// reset (arst_n low, asynchronous) clears all valid bits; data registers keep junk
module line_pair_intersection import lpi_pkg::*; (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// a_x1, a_y1, a_x2, a_y2, b_x1, b_y1, b_x2, b_y2 from bit 0 up
	input  logic [NUM_FIELDS*COORD_WIDTH-1:0] s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// cross_x, cross_y from bit 0 up
	output logic [2*COORD_WIDTH-1:0]          m_tdata,
	// found, clipped from bit 0 up
	output logic [1:0]                        m_tuser
);

	localparam int DW = COORD_WIDTH + 1;

	typedef struct packed {
		coord_t ax1, ay1, bx1, by1;
		logic   av, bv;
	} d1_t;

	typedef struct packed {
		coord_t ax1, ay1, bx1, by1;
		logic   av, bv;
		wide_t  sla, slb;
		logic   clip;
	} d2_t;

	typedef struct packed {
		logic  par, av, bv;
		wide_t ica, icb, sla, slb;
		logic  clip, gclip;
	} d3_t;

	typedef struct packed {
		logic  par;
		wide_t x, ic;
		logic  lclip, pclip;
	} d4_t;

	logic en;

	// valid bits
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic vd1_s [DIV_LAT];
	logic vm2_s [MUL_LAT];
	logic vd3_s [DIV_LAT];
	logic vm4_s [MUL_LAT];

	// payload stages
	coord_t in_s1 [NUM_FIELDS];
	d1_t    l_s2;
	wide_t  numa_s2, dena_s2, numb_s2, denb_s2;
	d1_t    d1_s [DIV_LAT];
	d2_t    l_s3;
	d2_t    d2_s [MUL_LAT];
	d3_t    l_s4;
	d3_t    l_s5;
	wide_t  num_s5, den_s5;
	d3_t    d3_s [DIV_LAT];
	d4_t    l_s6;
	wide_t  sl_s6;
	d4_t    d4_s [MUL_LAT];
	d4_t    l_s7;
	wide_t  y_s7;
	logic   found_s8, clip_s8;
	coord_t x_s8, y_s8;

	// unit outputs
	wide_t quoa, quob, quox, mula, mulb, mulf;
	logic  ovfa, ovfb, ovfx, mclipa, mclipb, mclipf;

	// whole pipe advances unless the output beat is stalled
	assign en       = !v_s8 || m_tready;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0;
			for (int i = 0; i < DIV_LAT; i++) begin
				vd1_s[i] <= 1'b0;
				vd3_s[i] <= 1'b0;
			end
			for (int i = 0; i < MUL_LAT; i++) begin
				vm2_s[i] <= 1'b0;
				vm4_s[i] <= 1'b0;
			end
		end else if (en) begin
			v_s1     <= s_tvalid;
			v_s2     <= v_s1;
			vd1_s[0] <= v_s2;
			for (int i = 1; i < DIV_LAT; i++) vd1_s[i] <= vd1_s[i-1];
			v_s3     <= vd1_s[DIV_LAT-1];
			vm2_s[0] <= v_s3;
			for (int i = 1; i < MUL_LAT; i++) vm2_s[i] <= vm2_s[i-1];
			v_s4     <= vm2_s[MUL_LAT-1];
			v_s5     <= v_s4;
			vd3_s[0] <= v_s5;
			for (int i = 1; i < DIV_LAT; i++) vd3_s[i] <= vd3_s[i-1];
			v_s6     <= vd3_s[DIV_LAT-1];
			vm4_s[0] <= v_s6;
			for (int i = 1; i < MUL_LAT; i++) vm4_s[i] <= vm4_s[i-1];
			v_s7     <= vm4_s[MUL_LAT-1];
			v_s8     <= v_s7;
		end
	end

	// input capture
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NUM_FIELDS; i++)
				in_s1[i] <= s_tdata[i*COORD_WIDTH +: COORD_WIDTH];
		end
	end

	// deltas, slope numerators and denominators, vertical flags
	logic signed [DW-1:0] dxa, dya, dxb, dyb;
	assign dxa = {in_s1[2][COORD_WIDTH-1], in_s1[2]} - {in_s1[0][COORD_WIDTH-1], in_s1[0]};
	assign dya = {in_s1[3][COORD_WIDTH-1], in_s1[3]} - {in_s1[1][COORD_WIDTH-1], in_s1[1]};
	assign dxb = {in_s1[6][COORD_WIDTH-1], in_s1[6]} - {in_s1[4][COORD_WIDTH-1], in_s1[4]};
	assign dyb = {in_s1[7][COORD_WIDTH-1], in_s1[7]} - {in_s1[5][COORD_WIDTH-1], in_s1[5]};

	always_ff @(posedge clk) begin
		if (en) begin
			l_s2.ax1 <= in_s1[0];
			l_s2.ay1 <= in_s1[1];
			l_s2.bx1 <= in_s1[4];
			l_s2.by1 <= in_s1[5];
			l_s2.av  <= in_s1[0] == in_s1[2];
			l_s2.bv  <= in_s1[4] == in_s1[6];
			numa_s2  <= {{(WIDE-DW-FRAC_BITS){dya[DW-1]}}, dya, {FRAC_BITS{1'b0}}};
			numb_s2  <= {{(WIDE-DW-FRAC_BITS){dyb[DW-1]}}, dyb, {FRAC_BITS{1'b0}}};
			dena_s2  <= {{(WIDE-DW){dxa[DW-1]}}, dxa};
			denb_s2  <= {{(WIDE-DW){dxb[DW-1]}}, dxb};
		end
	end

	// slope dividers
	lpi_div u_div_a (.clk, .en, .num(numa_s2), .den(dena_s2), .quo(quoa), .ovf(ovfa));
	lpi_div u_div_b (.clk, .en, .num(numb_s2), .den(denb_s2), .quo(quob), .ovf(ovfb));

	// slopes, vertical lines get zero
	always_ff @(posedge clk) begin
		if (en) begin
			d1_s[0] <= l_s2;
			for (int i = 1; i < DIV_LAT; i++) d1_s[i] <= d1_s[i-1];
			l_s3.ax1  <= d1_s[DIV_LAT-1].ax1;
			l_s3.ay1  <= d1_s[DIV_LAT-1].ay1;
			l_s3.bx1  <= d1_s[DIV_LAT-1].bx1;
			l_s3.by1  <= d1_s[DIV_LAT-1].by1;
			l_s3.av   <= d1_s[DIV_LAT-1].av;
			l_s3.bv   <= d1_s[DIV_LAT-1].bv;
			l_s3.sla  <= d1_s[DIV_LAT-1].av ? '0 : quoa;
			l_s3.slb  <= d1_s[DIV_LAT-1].bv ? '0 : quob;
			l_s3.clip <= (!d1_s[DIV_LAT-1].av && ovfa) || (!d1_s[DIV_LAT-1].bv && ovfb);
		end
	end

	// x1 times slope for each intercept
	lpi_mul u_mul_a (.clk, .en, .a(wide_t'(l_s3.ax1)), .b(l_s3.sla), .p(mula), .clip(mclipa));
	lpi_mul u_mul_b (.clk, .en, .a(wide_t'(l_s3.bx1)), .b(l_s3.slb), .p(mulb), .clip(mclipb));

	// intercepts
	d2_t  m2;
	sat_t suba, subb;
	assign m2   = d2_s[MUL_LAT-1];
	assign suba = sat_sub(wide_t'(m2.ay1), mula);
	assign subb = sat_sub(wide_t'(m2.by1), mulb);

	always_ff @(posedge clk) begin
		if (en) begin
			d2_s[0] <= l_s3;
			for (int i = 1; i < MUL_LAT; i++) d2_s[i] <= d2_s[i-1];
			l_s4.par   <= 1'b0;
			l_s4.av    <= m2.av;
			l_s4.bv    <= m2.bv;
			l_s4.sla   <= m2.sla;
			l_s4.slb   <= m2.slb;
			l_s4.ica   <= m2.av ? wide_t'(m2.ax1) : suba.v;
			l_s4.icb   <= m2.bv ? wide_t'(m2.bx1) : subb.v;
			l_s4.clip  <= m2.clip || (!m2.av && (mclipa || suba.clip))
				|| (!m2.bv && (mclipb || subb.clip));
			l_s4.gclip <= 1'b0;
		end
	end

	// parallel test and general-case numerator and denominator
	sat_t dic, shn;
	assign dic = sat_sub(l_s4.ica, l_s4.icb);
	assign shn = sat_shl(dic.v);

	always_ff @(posedge clk) begin
		if (en) begin
			l_s5.par   <= (l_s4.av && l_s4.bv)
				|| (!l_s4.av && !l_s4.bv && l_s4.sla == l_s4.slb);
			l_s5.av    <= l_s4.av;
			l_s5.bv    <= l_s4.bv;
			l_s5.ica   <= l_s4.ica;
			l_s5.icb   <= l_s4.icb;
			l_s5.sla   <= l_s4.sla;
			l_s5.slb   <= l_s4.slb;
			l_s5.clip  <= l_s4.clip;
			l_s5.gclip <= dic.clip || shn.clip;
			num_s5     <= shn.v;
			den_s5     <= l_s4.slb - l_s4.sla;
		end
	end

	// crossing x divider
	lpi_div u_div_x (.clk, .en, .num(num_s5), .den(den_s5), .quo(quox), .ovf(ovfx));

	// pick x, slope and intercept for the y product
	d3_t m3;
	logic gen3;
	assign m3   = d3_s[DIV_LAT-1];
	assign gen3 = !m3.par && !m3.av && !m3.bv;

	always_ff @(posedge clk) begin
		if (en) begin
			d3_s[0] <= l_s5;
			for (int i = 1; i < DIV_LAT; i++) d3_s[i] <= d3_s[i-1];
			l_s6.par   <= m3.par;
			l_s6.x     <= m3.bv ? m3.icb : (m3.av ? m3.ica : quox);
			l_s6.ic    <= m3.av ? m3.icb : m3.ica;
			sl_s6      <= m3.av ? m3.slb : m3.sla;
			l_s6.lclip <= m3.clip;
			l_s6.pclip <= gen3 && (m3.gclip || ovfx);
		end
	end

	// x times slope
	lpi_mul u_mul_f (.clk, .en, .a(l_s6.x), .b(sl_s6), .p(mulf), .clip(mclipf));

	// y
	d4_t  m4;
	sat_t ysum;
	assign m4   = d4_s[MUL_LAT-1];
	assign ysum = sat_add(mulf, m4.ic);

	always_ff @(posedge clk) begin
		if (en) begin
			d4_s[0] <= l_s6;
			for (int i = 1; i < MUL_LAT; i++) d4_s[i] <= d4_s[i-1];
			l_s7.par   <= m4.par;
			l_s7.x     <= m4.x;
			l_s7.ic    <= m4.ic;
			l_s7.lclip <= m4.lclip;
			l_s7.pclip <= m4.pclip || mclipf || ysum.clip;
			y_s7       <= ysum.v;
		end
	end

	// output saturation and parallel override
	logic [WIDE-COORD_WIDTH:0] xtop, ytop;
	logic                      xok, yok;
	assign xtop = l_s7.x[WIDE-1:COORD_WIDTH-1];
	assign ytop = y_s7[WIDE-1:COORD_WIDTH-1];
	assign xok  = (&xtop) || !(|xtop);
	assign yok  = (&ytop) || !(|ytop);

	always_ff @(posedge clk) begin
		if (en) begin
			if (l_s7.par) begin
				found_s8 <= 1'b0;
				x_s8     <= '0;
				y_s8     <= '0;
				clip_s8  <= l_s7.lclip;
			end else begin
				found_s8 <= 1'b1;
				x_s8     <= xok ? l_s7.x[COORD_WIDTH-1:0]
					: (l_s7.x[WIDE-1] ? {1'b1, {(COORD_WIDTH-1){1'b0}}}
					: {1'b0, {(COORD_WIDTH-1){1'b1}}});
				y_s8     <= yok ? y_s7[COORD_WIDTH-1:0]
					: (y_s7[WIDE-1] ? {1'b1, {(COORD_WIDTH-1){1'b0}}}
					: {1'b0, {(COORD_WIDTH-1){1'b1}}});
				clip_s8  <= l_s7.lclip || l_s7.pclip || !xok || !yok;
			end
		end
	end

	assign m_tvalid = v_s8;
	assign m_tdata  = {y_s8, x_s8};
	assign m_tuser  = {clip_s8, found_s8};

endmodule
